### rtl/core/ddeo_pkg.sv
// shared types, constants and tables for the wheel odometry block
`default_nettype none
package ddeo_pkg;

	// cordic configuration
	localparam int CORDIC_STEPS = 16;
	localparam int ITW = $clog2(CORDIC_STEPS);
	localparam int CW = 33;
	localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;
	localparam logic signed [CW-1:0] QUARTER = 33'sh040000000;
	localparam logic signed [CW-1:0] HALF_TURN = 33'sh080000000;

	// datapath widths
	localparam int MA_W = 40;
	localparam int MB_W = 18;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W = 68;
	localparam int SPLIT = 17;
	localparam int SUM_W = 34;
	localparam int T_W = 32;
	localparam int Q36_W = 50;
	localparam int Q24_W = 38;
	localparam int SAT_W = 44;
	localparam int SH_W = 6;

	// radians (q.24) to binary angle (q.20) factor, split at SPLIT bits
	localparam logic [MB_W-1:0] K_HI = 18'd325;
	localparam logic [MB_W-1:0] K_LO = 18'd124430;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_AXIS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE = 2'd2;
	localparam logic [15:0] RADIUS_RESET = 16'd1311;
	localparam logic [15:0] INV_AXIS_RESET = 16'd4491;
	localparam logic [9:0] STEP_RATE_RESET = 10'd31;

	// channel payloads
	typedef struct packed {
		logic signed [15:0] left_wheel_delta;
		logic signed [15:0] right_wheel_delta;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic [31:0] out_heading;
		logic signed [23:0] forward_speed;
		logic signed [23:0] turn_rate;
	} result_t;

	// multiply-accumulate unit control
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic shacc;
		logic rnd_en;
		logic [SH_W-1:0] shamt;
	} mac_ctrl_t;

	// operand and destination selects of one microcode op
	typedef enum logic [2:0] {
		A_SUM17, A_RADIUS, A_T, A_SUM, A_Q24, A_Q36_HI, A_Q36_LO
	} a_sel_t;

	typedef enum logic [3:0] {
		B_RADIUS, B_INV, B_DIFF, B_C_HI, B_C_LO, B_S_HI, B_S_LO, B_K_HI, B_K_LO, B_RATE
	} b_sel_t;

	typedef enum logic [3:0] {
		D_NONE, D_SUM, D_T, D_Q36, D_X, D_Y, D_H, D_V, D_W
	} dest_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		logic shacc;
		logic last;
		logic [SH_W-1:0] shamt;
		dest_t dest;
	} op_t;

	// microcode op indexes
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_SUM = 4'd0;
	localparam logic [OP_W-1:0] OP_T = 4'd1;
	localparam logic [OP_W-1:0] OP_Q36 = 4'd2;
	localparam logic [OP_W-1:0] OP_X_HI = 4'd3;
	localparam logic [OP_W-1:0] OP_X_LO = 4'd4;
	localparam logic [OP_W-1:0] OP_Y_HI = 4'd5;
	localparam logic [OP_W-1:0] OP_Y_LO = 4'd6;
	localparam logic [OP_W-1:0] OP_H_HI = 4'd7;
	localparam logic [OP_W-1:0] OP_H_LO = 4'd8;
	localparam logic [OP_W-1:0] OP_V = 4'd9;
	localparam logic [OP_W-1:0] OP_W_HI = 4'd10;
	localparam logic [OP_W-1:0] OP_W_LO = 4'd11;
	localparam logic [OP_W-1:0] OP_LAST = OP_W_LO;

	// microcode table
	function automatic op_t op_entry(input logic [OP_W-1:0] idx);
		op_t o;
		o = '{a_sel: A_SUM17, b_sel: B_RADIUS, shacc: 1'b0, last: 1'b1,
			shamt: 6'd0, dest: D_NONE};
		case (idx)
			OP_SUM: begin
				o = '{a_sel: A_SUM17, b_sel: B_RADIUS, shacc: 1'b0, last: 1'b1,
					shamt: 6'd0, dest: D_SUM};
			end
			OP_T: begin
				o = '{a_sel: A_RADIUS, b_sel: B_INV, shacc: 1'b0, last: 1'b1,
					shamt: 6'd0, dest: D_T};
			end
			OP_Q36: begin
				o = '{a_sel: A_T, b_sel: B_DIFF, shacc: 1'b0, last: 1'b1,
					shamt: 6'd12, dest: D_Q36};
			end
			OP_X_HI: begin
				o = '{a_sel: A_SUM, b_sel: B_C_HI, shacc: 1'b0, last: 1'b0,
					shamt: 6'd0, dest: D_NONE};
			end
			OP_X_LO: begin
				o = '{a_sel: A_SUM, b_sel: B_C_LO, shacc: 1'b1, last: 1'b1,
					shamt: 6'd43, dest: D_X};
			end
			OP_Y_HI: begin
				o = '{a_sel: A_SUM, b_sel: B_S_HI, shacc: 1'b0, last: 1'b0,
					shamt: 6'd0, dest: D_NONE};
			end
			OP_Y_LO: begin
				o = '{a_sel: A_SUM, b_sel: B_S_LO, shacc: 1'b1, last: 1'b1,
					shamt: 6'd43, dest: D_Y};
			end
			OP_H_HI: begin
				o = '{a_sel: A_Q24, b_sel: B_K_HI, shacc: 1'b0, last: 1'b0,
					shamt: 6'd0, dest: D_NONE};
			end
			OP_H_LO: begin
				o = '{a_sel: A_Q24, b_sel: B_K_LO, shacc: 1'b1, last: 1'b1,
					shamt: 6'd20, dest: D_H};
			end
			OP_V: begin
				o = '{a_sel: A_SUM, b_sel: B_RATE, shacc: 1'b0, last: 1'b1,
					shamt: 6'd13, dest: D_V};
			end
			OP_W_HI: begin
				o = '{a_sel: A_Q36_HI, b_sel: B_RATE, shacc: 1'b0, last: 1'b0,
					shamt: 6'd0, dest: D_NONE};
			end
			OP_W_LO: begin
				o = '{a_sel: A_Q36_LO, b_sel: B_RATE, shacc: 1'b1, last: 1'b1,
					shamt: 6'd20, dest: D_W};
			end
			default: begin
				o = '{a_sel: A_SUM17, b_sel: B_RADIUS, shacc: 1'b0, last: 1'b1,
					shamt: 6'd0, dest: D_NONE};
			end
		endcase
		return o;
	endfunction

	// arctangent of 2^-i in binary angle units
	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] r;
		r = 32'd0;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/core/ddeo_cordic.sv
// iterative rotation-mode cordic giving cos and sin of a binary angle
`default_nettype none
module ddeo_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [31:0] angle,
	output logic done,
	output logic signed [ddeo_pkg::CW-1:0] cos_val,
	output logic signed [ddeo_pkg::CW-1:0] sin_val
);

	logic signed [ddeo_pkg::CW-1:0] x_q, y_q, z_q;
	logic flip_q;
	logic busy_q;
	logic done_q;
	logic [ddeo_pkg::ITW-1:0] it_q;

	logic signed [ddeo_pkg::CW-1:0] z_raw, z_fold;
	logic flip_fold;
	logic signed [ddeo_pkg::CW-1:0] dx, dy, da;
	logic last_it;

	// fold the angle into plus or minus a quarter turn
	always_comb begin
		z_raw = {angle[31], angle};
		z_fold = z_raw;
		flip_fold = 1'b0;
		if (z_raw > ddeo_pkg::QUARTER) begin
			z_fold = z_raw - ddeo_pkg::HALF_TURN;
			flip_fold = 1'b1;
		end else if (z_raw < -ddeo_pkg::QUARTER) begin
			z_fold = z_raw + ddeo_pkg::HALF_TURN;
			flip_fold = 1'b1;
		end
	end

	// shared shift and add step
	always_comb begin
		dx = y_q >>> it_q;
		dy = x_q >>> it_q;
		da = {1'b0, ddeo_pkg::atan_bam(5'(it_q))};
		last_it = (it_q == ddeo_pkg::ITW'(ddeo_pkg::CORDIC_STEPS - 1));
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q <= '0;
			end else if (busy_q) begin
				if (last_it) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					it_q <= it_q + 1'b1;
				end
			end
		end
	end

	// vector and angle registers
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= ddeo_pkg::GAIN_Q30;
			y_q <= '0;
			z_q <= z_fold;
			flip_q <= flip_fold;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end
		end
	end

	assign done = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule
`default_nettype wire

### rtl/core/ddeo_mac.sv
// shared multiplier with split-product accumulator and rounding shifter
`default_nettype none
module ddeo_mac (
	input wire logic clk,
	input wire ddeo_pkg::mac_ctrl_t ctrl,
	input wire logic signed [ddeo_pkg::MA_W-1:0] a,
	input wire logic signed [ddeo_pkg::MB_W-1:0] b,
	output logic signed [ddeo_pkg::ACC_W-1:0] acc,
	output logic signed [ddeo_pkg::ACC_W-1:0] rnd
);

	logic signed [ddeo_pkg::PROD_W-1:0] prod_q;
	logic signed [ddeo_pkg::ACC_W-1:0] acc_q;
	logic signed [ddeo_pkg::ACC_W-1:0] rnd_q;
	logic signed [ddeo_pkg::ACC_W-1:0] prod_ext;
	logic [ddeo_pkg::ACC_W-1:0] half;
	logic signed [ddeo_pkg::ACC_W-1:0] biased;

	// sign-extended product and rounding bias
	always_comb begin
		prod_ext = {{(ddeo_pkg::ACC_W - ddeo_pkg::PROD_W){prod_q[ddeo_pkg::PROD_W-1]}},
			prod_q};
		half = ({{(ddeo_pkg::ACC_W - 1){1'b0}}, 1'b1} << ctrl.shamt) >> 1;
		biased = acc_q + $signed(half);
	end

	// multiply, accumulate, round: one step each
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= a * b;
		end
		if (ctrl.acc_en) begin
			if (ctrl.shacc) begin
				acc_q <= (acc_q <<< ddeo_pkg::SPLIT) + prod_ext;
			end else begin
				acc_q <= prod_ext;
			end
		end
		if (ctrl.rnd_en) begin
			rnd_q <= biased >>> ctrl.shamt;
		end
	end

	assign acc = acc_q;
	assign rnd = rnd_q;

endmodule
`default_nettype wire

### rtl/core/diff_drive_encoder_odometry_top.sv
// differential-drive wheel odometry: sequencer, state and configuration
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  sample   | sample_valid / stall | ddeo_pkg::sample_t, wheel deltas
//  result   | result_valid / stall | ddeo_pkg::result_t, pose, speeds
//  cfg      | cfg_valid / ready    | cfg_index, cfg_data
//
// each item runs the cordic iterations, then twelve passes through the one
// multiplier (multiply and accumulate for every pass, then round and write back
// for each pass that ends a product), then loads the output register; no new
// sample is taken until the item has left the sequencer.
// arst_n clears position, heading and control and loads register defaults.
// the result sits in an output register, so the next item is taken while it
// waits; a finished item waits only if that register is still full.
`default_nettype none
module diff_drive_encoder_odometry_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_stall,
	input wire ddeo_pkg::sample_t sample,
	output logic result_valid,
	input wire logic result_stall,
	output ddeo_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [ddeo_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [15:0] cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CORD = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_ACC  = 7'b0001000,
		S_RND  = 7'b0010000,
		S_WB   = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [ddeo_pkg::OP_W-1:0] op_q;
	ddeo_pkg::op_t op;

	logic [15:0] radius_q;
	logic [15:0] inv_axis_q;
	logic [9:0] rate_q;

	logic signed [31:0] x_q, y_q;
	logic [31:0] heading_q;

	logic signed [16:0] sum17_q, diff17_q;
	logic signed [ddeo_pkg::SUM_W-1:0] sum_q;
	logic [ddeo_pkg::T_W-1:0] t_q;
	logic signed [ddeo_pkg::Q36_W-1:0] q36_q;
	logic signed [ddeo_pkg::Q24_W-1:0] q24_q;
	logic signed [ddeo_pkg::CW-1:0] c_q, s_q;
	logic signed [23:0] v_q, w_q;

	logic res_valid_q;
	ddeo_pkg::result_t result_q;

	logic accept;
	logic cord_done;
	logic signed [ddeo_pkg::CW-1:0] cord_cos, cord_sin;
	ddeo_pkg::mac_ctrl_t mac_ctrl;
	logic signed [ddeo_pkg::MA_W-1:0] mac_a;
	logic signed [ddeo_pkg::MB_W-1:0] mac_b;
	logic signed [ddeo_pkg::ACC_W-1:0] mac_acc, mac_rnd;
	logic signed [ddeo_pkg::SUM_W-1:0] x_next, y_next;
	logic out_free;

	// saturate a position sum to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [ddeo_pkg::SUM_W-1:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v > 34'sh07FFFFFFF) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -34'sh080000000) begin
			r = 32'sh80000000;
		end
		return r;
	endfunction

	// saturate a speed to 24 bits
	function automatic logic signed [23:0] sat24(input logic signed [ddeo_pkg::SAT_W-1:0] v);
		logic signed [23:0] r;
		r = v[23:0];
		if (v > 44'sh000007FFFFF) begin
			r = 24'sh7FFFFF;
		end else if (v < -44'sh00000800000) begin
			r = 24'sh800000;
		end
		return r;
	endfunction

	assign accept = sample_valid && !sample_stall;
	assign sample_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !res_valid_q || !result_stall;
	assign op = ddeo_pkg::op_entry(op_q);

	ddeo_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.angle(heading_q),
		.done(cord_done),
		.cos_val(cord_cos),
		.sin_val(cord_sin)
	);

	// operand selection for the shared multiplier
	always_comb begin
		mac_a = '0;
		case (op.a_sel)
			ddeo_pkg::A_SUM17: mac_a = {{23{sum17_q[16]}}, sum17_q};
			ddeo_pkg::A_RADIUS: mac_a = {24'd0, radius_q};
			ddeo_pkg::A_T: mac_a = {8'd0, t_q};
			ddeo_pkg::A_SUM: mac_a = {{6{sum_q[ddeo_pkg::SUM_W-1]}}, sum_q};
			ddeo_pkg::A_Q24: mac_a = {{2{q24_q[ddeo_pkg::Q24_W-1]}}, q24_q};
			ddeo_pkg::A_Q36_HI: mac_a = {{7{q36_q[ddeo_pkg::Q36_W-1]}},
				q36_q[ddeo_pkg::Q36_W-1:ddeo_pkg::SPLIT]};
			ddeo_pkg::A_Q36_LO: mac_a = {23'd0, q36_q[ddeo_pkg::SPLIT-1:0]};
			default: mac_a = '0;
		endcase
		mac_b = '0;
		case (op.b_sel)
			ddeo_pkg::B_RADIUS: mac_b = {2'b00, radius_q};
			ddeo_pkg::B_INV: mac_b = {2'b00, inv_axis_q};
			ddeo_pkg::B_DIFF: mac_b = {diff17_q[16], diff17_q};
			ddeo_pkg::B_C_HI: mac_b = {{2{c_q[ddeo_pkg::CW-1]}},
				c_q[ddeo_pkg::CW-1:ddeo_pkg::SPLIT]};
			ddeo_pkg::B_C_LO: mac_b = {1'b0, c_q[ddeo_pkg::SPLIT-1:0]};
			ddeo_pkg::B_S_HI: mac_b = {{2{s_q[ddeo_pkg::CW-1]}},
				s_q[ddeo_pkg::CW-1:ddeo_pkg::SPLIT]};
			ddeo_pkg::B_S_LO: mac_b = {1'b0, s_q[ddeo_pkg::SPLIT-1:0]};
			ddeo_pkg::B_K_HI: mac_b = ddeo_pkg::K_HI;
			ddeo_pkg::B_K_LO: mac_b = ddeo_pkg::K_LO;
			ddeo_pkg::B_RATE: mac_b = {8'd0, rate_q};
			default: mac_b = '0;
		endcase
	end

	// multiplier step controls
	always_comb begin
		mac_ctrl.mul_en = (state_q == S_MUL);
		mac_ctrl.acc_en = (state_q == S_ACC);
		mac_ctrl.shacc = op.shacc;
		mac_ctrl.rnd_en = (state_q == S_RND);
		mac_ctrl.shamt = op.shamt;
	end

	ddeo_mac u_mac (
		.clk(clk),
		.ctrl(mac_ctrl),
		.a(mac_a),
		.b(mac_b),
		.acc(mac_acc),
		.rnd(mac_rnd)
	);

	// position sums before saturation
	always_comb begin
		x_next = {{2{x_q[31]}}, x_q} + mac_rnd[ddeo_pkg::SUM_W-1:0];
		y_next = {{2{y_q[31]}}, y_q} + mac_rnd[ddeo_pkg::SUM_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (cord_done) begin
						op_q <= ddeo_pkg::OP_SUM;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (op.last) begin
						state_q <= S_RND;
					end else begin
						op_q <= op_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_RND: begin
					state_q <= S_WB;
				end
				S_WB: begin
					if (op_q == ddeo_pkg::OP_LAST) begin
						state_q <= S_FIN;
					end else begin
						op_q <= op_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// configuration registers and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= ddeo_pkg::RADIUS_RESET;
			inv_axis_q <= ddeo_pkg::INV_AXIS_RESET;
			rate_q <= ddeo_pkg::STEP_RATE_RESET;
			x_q <= '0;
			y_q <= '0;
			heading_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ddeo_pkg::REG_WHEEL_RADIUS: radius_q <= cfg_data;
					ddeo_pkg::REG_INVERSE_AXIS: inv_axis_q <= cfg_data;
					ddeo_pkg::REG_STEP_RATE: rate_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (state_q == S_WB) begin
				case (op.dest)
					ddeo_pkg::D_X: x_q <= sat32(x_next);
					ddeo_pkg::D_Y: y_q <= sat32(y_next);
					ddeo_pkg::D_H: heading_q <= heading_q + mac_rnd[31:0];
					default: ;
				endcase
			end
		end
	end

	// item working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sum17_q <= {sample.left_wheel_delta[15], sample.left_wheel_delta}
				+ {sample.right_wheel_delta[15], sample.right_wheel_delta};
			diff17_q <= {sample.right_wheel_delta[15], sample.right_wheel_delta}
				- {sample.left_wheel_delta[15], sample.left_wheel_delta};
		end
		if (cord_done) begin
			c_q <= cord_cos;
			s_q <= cord_sin;
		end
		if (state_q == S_WB) begin
			case (op.dest)
				ddeo_pkg::D_SUM: sum_q <= mac_rnd[ddeo_pkg::SUM_W-1:0];
				ddeo_pkg::D_T: t_q <= mac_rnd[ddeo_pkg::T_W-1:0];
				ddeo_pkg::D_Q36: begin
					q36_q <= mac_acc[ddeo_pkg::Q36_W-1:0];
					q24_q <= mac_rnd[ddeo_pkg::Q24_W-1:0];
				end
				ddeo_pkg::D_V: v_q <= sat24(mac_rnd[ddeo_pkg::SAT_W-1:0]);
				ddeo_pkg::D_W: w_q <= sat24(mac_rnd[ddeo_pkg::SAT_W-1:0]);
				default: ;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			result_q.out_x <= x_q;
			result_q.out_y <= y_q;
			result_q.out_heading <= heading_q;
			result_q.forward_speed <= v_q;
			result_q.turn_rate <= w_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result = result_q;

endmodule
`default_nettype wire

### bench/diff_drive_encoder_odometry_top_test.sv
// self-checking testbench for the wheel odometry block: pose prediction, random traffic
`timescale 1ns / 1ps
module diff_drive_encoder_odometry_top_test;
	import ddeo_pkg::*;

	localparam int unsigned LIMIT = 4000000;
	localparam int MAX_SHOWN = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic signed [15:0] WHEEL_MAX = 16'sh7fff;
	localparam logic signed [15:0] WHEEL_MIN = 16'sh8000;

	// arctangent of 2^-i in binary angle units (2^32 per turn)
	localparam longint ATAN_TURN [0:30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1
	};

	// opening items: extremes, single steps, wrapping turns, moves at several headings
	localparam logic signed [15:0] OPEN_LEFT [0:22] = '{
		16'sd0, 16'sd1, -16'sd1, 16'sd1, -16'sd1,
		WHEEL_MAX, WHEEL_MIN, WHEEL_MAX, WHEEL_MIN, WHEEL_MAX, WHEEL_MAX,
		WHEEL_MIN, WHEEL_MIN, WHEEL_MIN,
		-16'sd12000, 16'sd16000, -16'sd12000, 16'sd16000, -16'sd12000, 16'sd16000,
		16'sd12000, WHEEL_MIN, 16'sd0
	};
	localparam logic signed [15:0] OPEN_RIGHT [0:22] = '{
		16'sd0, 16'sd1, -16'sd1, -16'sd1, 16'sd1,
		WHEEL_MAX, WHEEL_MIN, WHEEL_MIN, WHEEL_MAX, WHEEL_MIN, WHEEL_MIN,
		WHEEL_MAX, WHEEL_MAX, WHEEL_MAX,
		16'sd12000, 16'sd16000, 16'sd12000, 16'sd16000, 16'sd12000, 16'sd16000,
		-16'sd12000, 16'sd0, WHEEL_MAX
	};

	// pose predictor and queue of poses still to come out
	class pose_tracker;
		longint radius;
		longint inv_axis;
		longint rate;
		longint x_pos;
		longint y_pos;
		logic [31:0] heading;
		result_t pending_poses[$];
		int failures;
		int shown;

		function new();
			radius = RADIUS_RESET;
			inv_axis = INV_AXIS_RESET;
			rate = STEP_RATE_RESET;
			x_pos = 0;
			y_pos = 0;
			heading = '0;
			failures = 0;
			shown = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				REG_WHEEL_RADIUS: radius = data;
				REG_INVERSE_AXIS: inv_axis = data;
				REG_STEP_RATE: rate = data[9:0];
				default: ;
			endcase
		endfunction

		// add one half, then floor
		static function longint round_sh(longint v, int s);
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		static function longint clamp(longint v, int bits);
			longint hi;
			longint lo;
			hi = (longint'(1) << (bits - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		// rotation-mode cordic on the folded angle, q.30 outputs
		function void sin_cos(logic [31:0] angle, output longint c, output longint s);
			longint z;
			longint x;
			longint y;
			longint nx;
			bit flip;
			z = {32'd0, angle};
			x = GAIN_Q30;
			y = 0;
			flip = 1'b0;
			if (z >= (longint'(1) << 31))
				z = z - (longint'(1) << 32);
			if (z > (longint'(1) << 30)) begin
				z = z - (longint'(1) << 31);
				flip = 1'b1;
			end else if (z < -(longint'(1) << 30)) begin
				z = z + (longint'(1) << 31);
				flip = 1'b1;
			end
			for (int i = 0; i < CORDIC_STEPS && i < 31; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z = z - ATAN_TURN[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z = z + ATAN_TURN[i];
				end
				x = nx;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		// one euler step from the heading held before the item
		function void advance_pose(sample_t smp);
			longint dl;
			longint dr;
			longint sum;
			longint q36;
			longint c;
			longint s;
			longint q24;
			longint dh;
			longint v;
			longint w;
			result_t pose;
			dl = longint'($signed(smp.left_wheel_delta)) * radius;
			dr = longint'($signed(smp.right_wheel_delta)) * radius;
			sum = dl + dr;
			q36 = (dr - dl) * inv_axis;
			sin_cos(heading, c, s);
			x_pos = clamp(x_pos + round_sh(sum * c, 43), 32);
			y_pos = clamp(y_pos + round_sh(sum * s, 43), 32);
			q24 = round_sh(q36, 12);
			dh = round_sh(q24 * 64'sd42722830, 20);
			heading = heading + dh[31:0];
			v = clamp(round_sh(sum * rate, 13), 24);
			w = clamp(round_sh(q36 * rate, 20), 24);
			pose.out_x = x_pos[31:0];
			pose.out_y = y_pos[31:0];
			pose.out_heading = heading;
			pose.forward_speed = v[23:0];
			pose.turn_rate = w[23:0];
			pending_poses.push_back(pose);
		endfunction

		function void note_mismatch(string field, logic signed [63:0] want,
				logic signed [63:0] got);
			failures++;
			if (shown < MAX_SHOWN) begin
				shown++;
				$display("mismatch on %s: expected %0d, got %0d", field, want, got);
			end
		endfunction

		function void check_pose(result_t got);
			result_t want;
			if (pending_poses.size() == 0) begin
				failures++;
				if (shown < MAX_SHOWN) begin
					shown++;
					$display("result with no pending pose: %p", got);
				end
				return;
			end
			want = pending_poses.pop_front();
			if (got.out_x !== want.out_x)
				note_mismatch("out_x", want.out_x, got.out_x);
			if (got.out_y !== want.out_y)
				note_mismatch("out_y", want.out_y, got.out_y);
			if (got.out_heading !== want.out_heading)
				note_mismatch("out_heading", want.out_heading, got.out_heading);
			if (got.forward_speed !== want.forward_speed)
				note_mismatch("forward_speed", want.forward_speed, got.forward_speed);
			if (got.turn_rate !== want.turn_rate)
				note_mismatch("turn_rate", want.turn_rate, got.turn_rate);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t wheel_sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t pose_result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int unsigned cycles = 0;
	bit calm = 1'b0;
	pose_tracker tracker;

	always #5 clk = ~clk;

	diff_drive_encoder_odometry_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(wheel_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(pose_result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stall before each item, then check it
	initial begin
		int hold;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (result_valid !== 1'b1);
			tracker.check_pose(pose_result);
		end
	end

	// one wheel item, valid held high across back-to-back items
	task automatic send_wheels(input logic signed [15:0] left, input logic signed [15:0] right);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		wheel_sample <= '{left_wheel_delta: left, right_wheel_delta: right};
		do @(posedge clk); while (sample_stall);
		tracker.advance_pose(wheel_sample);
	endtask

	// stop sending until every pose has come out
	task automatic wait_for_poses();
		sample_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_poses.size() != 0);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
	endtask

	// all three registers plus a write to the unused index
	task automatic set_geometry(input logic [15:0] radius, input logic [15:0] inv,
			input logic [15:0] rate);
		put_reg(REG_WHEEL_RADIUS, radius);
		put_reg(REG_INVERSE_AXIS, inv);
		put_reg(REG_STEP_RATE, rate);
		put_reg(REG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] wheel_value();
		logic signed [15:0] v;
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 4))
					0: v = WHEEL_MAX;
					1: v = WHEEL_MIN;
					2: v = 16'sd0;
					3: v = 16'sd1;
					default: v = -16'sd1;
				endcase
			end
			1, 2: v = 16'($urandom_range(0, 4000) - 2000);
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// random items, some straight, some spinning in place
	task automatic random_run(input int count);
		logic signed [15:0] left;
		logic signed [15:0] right;
		calm = ($urandom_range(0, 3) == 0);
		for (int n = 0; n < count; n++) begin
			left = wheel_value();
			case ($urandom_range(0, 5))
				0: right = left;
				1: right = -left;
				default: right = wheel_value();
			endcase
			if ($urandom_range(0, 49) == 0)
				wait_for_poses();
			send_wheels(left, right);
		end
	endtask

	initial begin
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items under the reset geometry
		for (int i = 0; i < 23; i++)
			send_wheels(OPEN_LEFT[i], OPEN_RIGHT[i]);
		random_run(60);

		// register extremes, zero registers and random settings
		wait_for_poses();
		set_geometry(16'hffff, 16'hffff, 16'd1023);
		random_run(70);
		wait_for_poses();
		set_geometry(16'd1, 16'd1, 16'd1);
		random_run(60);
		wait_for_poses();
		set_geometry(16'd0, 16'd0, 16'd0);
		random_run(50);
		wait_for_poses();
		set_geometry(16'd40000, 16'd300, 16'd1000);
		random_run(60);
		repeat (3) begin
			wait_for_poses();
			set_geometry(16'($urandom), 16'($urandom), 16'($urandom));
			random_run(45);
		end

		// drain and watch for stray results
		wait_for_poses();
		repeat (120) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_poses.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
